// ===== rtl/oat_pkg.sv =====
// Package for the ordered array table: sizes, codes and the cell command type.
`timescale 1ns / 1ps

package oat_pkg;

    localparam int DEPTH  = 64;
    localparam int WW     = 32;                       // entry width
    localparam int CW     = $clog2(DEPTH + 1);        // fill count / position width
    localparam int IW     = $clog2(DEPTH);            // entry index width
    localparam int IN_DW  = ((WW + CW + 7) / 8) * 8;
    localparam int OUT_DW = ((IW + WW + CW + 7) / 8) * 8;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_INSERT = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_DELETE = 3'd4,
        ACT_READ   = 3'd5
    } t_act;

    typedef enum logic [ST_W-1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_BADPOS   = 2'd2,
        STS_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND,
        ST_DONE
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        t_op                   op;
        logic [CW-1:0]         pos;
        logic [CW-1:0]         cnt;
        logic signed [WW-1:0]  val;
    } t_cmd;

endpackage

// ===== rtl/oat_cell.sv =====
// One entry of the table: holds a word, shifts with its neighbours, compares.
`timescale 1ns / 1ps

module oat_cell import oat_pkg::*; (
    input  logic                 i_clk,
    input  t_cmd                 i_cmd,
    input  logic [IW-1:0]        i_index,
    input  logic signed [WW-1:0] i_left,
    input  logic signed [WW-1:0] i_right,
    output logic signed [WW-1:0] o_entry,
    output logic                 o_match,
    output logic signed [WW-1:0] o_rd
);

    logic signed [WW-1:0] r_entry;
    logic signed [WW-1:0] n_entry;
    logic [CW-1:0]        w_idx;

    assign w_idx = CW'(i_index);

    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (w_idx == i_cmd.pos) begin
                    n_entry = i_cmd.val;
                end else if (w_idx > i_cmd.pos && w_idx <= i_cmd.cnt) begin
                    n_entry = i_left;
                end
            end
            OP_DELETE: begin
                if (w_idx >= i_cmd.pos && (w_idx + CW'(1)) < i_cmd.cnt) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // only live entries may match
    assign o_match = (r_entry == i_cmd.val) && (w_idx < i_cmd.cnt);
    assign o_rd    = (w_idx == i_cmd.pos) ? r_entry : '0;

endmodule

// ===== rtl/oat_prio.sv =====
// Lowest-set-bit encoder over the match vector, in groups of eight.
`timescale 1ns / 1ps

module oat_prio import oat_pkg::*; (
    input  logic [DEPTH-1:0] i_vec,
    output logic             o_any,
    output logic [IW-1:0]    o_index
);

    localparam int GRP  = 8;
    localparam int LW   = $clog2(GRP);
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NG2  = 1 << GW;

    logic [NG2*GRP-1:0] w_vec;
    logic [NG2-1:0]     w_gany;
    logic [LW-1:0]      w_glow [NG2];
    logic [GW-1:0]      w_sel;

    always_comb begin
        w_vec = '0;
        w_vec[DEPTH-1:0] = i_vec;
        for (int g = 0; g < NG2; g++) begin
            w_gany[g] = |w_vec[g*GRP +: GRP];
            w_glow[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (w_vec[g*GRP + j]) begin
                    w_glow[g] = LW'(j);
                end
            end
        end
        w_sel = '0;
        for (int g = NG2 - 1; g >= 0; g--) begin
            if (w_gany[g]) begin
                w_sel = GW'(g);
            end
        end
    end

    assign o_any   = |w_gany;
    assign o_index = IW'({w_sel, w_glow[w_sel]});

endmodule

// ===== rtl/ordered_array_table.sv =====
// Top level of the ordered array table: control, fill count and the cell row.
`timescale 1ns / 1ps

// Ordered array table: a bounded row of DEPTH signed 32-bit entries with a
// fill count, one entry per cell. Each input item carries an action (clear,
// append, insert, search, delete, read) and gives exactly one result item
// with a status, the fill count after the action and, for search and read,
// the found index or the entry read. Items are handled one at a time: an
// item is taken in IDLE, executed in the following cycle (all cells shift
// or compare together), and its result is shown from the cycle after that
// until taken; a search first goes through an extra FIND state, where the
// lowest-match encoder runs on the registered match vector. Entries hold
// no reset value; only entries below the fill count are ever read. Reset
// clears only the fill count and the control state.

module ordered_array_table import oat_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [WW-1:0] value, [WW+CW-1:WW] position, zero fill above
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // [2:0] action
    input  logic [ACT_W-1:0]  s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [IW-1:0] found_index, [IW+WW-1:IW] read_value,
    // [IW+WW+CW-1:IW+WW] fill_count, zero fill above
    output logic [OUT_DW-1:0] m_axis_tdata,
    // [1:0] status
    output logic [ST_W-1:0]   m_axis_tuser
);

    t_state r_state, n_state;

    // captured item
    t_act                 r_act;
    logic signed [WW-1:0] r_val;
    logic [CW-1:0]        r_pos;

    logic [CW-1:0]        r_count, n_count;

    // result registers
    t_status              r_status, n_status;
    logic [IW-1:0]        r_found, n_found;
    logic signed [WW-1:0] r_rdval, n_rdval;
    logic [DEPTH-1:0]     r_match;

    logic                 w_exec;
    logic                 w_full;
    t_cmd                 w_cmd;
    logic signed [WW-1:0] w_entry [DEPTH];
    logic signed [WW-1:0] w_rd    [DEPTH];
    logic [DEPTH-1:0]     w_match;
    logic signed [WW-1:0] w_rdsum;
    logic                 w_any;
    logic [IW-1:0]        w_pidx;

    // ---- state machine: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_EXEC;
            ST_EXEC: n_state = (r_act == ACT_SEARCH) ? ST_FIND : ST_DONE;
            ST_FIND: n_state = ST_DONE;
            ST_DONE: if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- state machine: outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_exec        = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: w_exec        = 1'b1;
            ST_FIND: ;
            ST_DONE: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // capture the item
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_act <= t_act'(s_axis_tuser);
            r_val <= s_axis_tdata[WW-1:0];
            r_pos <= s_axis_tdata[WW +: CW];
        end
    end

    // ---- execute: decide the action, drive the cells
    assign w_full = (r_count >= CW'(DEPTH));

    always_comb begin
        w_cmd.op  = OP_NONE;
        w_cmd.pos = r_pos;
        w_cmd.cnt = r_count;
        w_cmd.val = r_val;
        n_count   = r_count;
        n_status  = r_status;
        n_found   = r_found;
        n_rdval   = r_rdval;
        if (w_exec) begin
            n_status = STS_OK;
            n_found  = '0;
            n_rdval  = '0;
            case (r_act)
                ACT_CLEAR: n_count = '0;
                ACT_APPEND: begin
                    if (w_full) begin
                        n_status = STS_FULL;
                    end else begin
                        // append is an insert at the fill count
                        w_cmd.op  = OP_INSERT;
                        w_cmd.pos = r_count;
                        n_count   = r_count + CW'(1);
                    end
                end
                ACT_INSERT: begin
                    if (w_full) begin
                        n_status = STS_FULL;
                    end else if (r_pos > r_count) begin
                        n_status = STS_BADPOS;
                    end else begin
                        w_cmd.op = OP_INSERT;
                        n_count  = r_count + CW'(1);
                    end
                end
                ACT_SEARCH: n_status = STS_NOTFOUND;
                ACT_DELETE: begin
                    if (r_pos >= r_count) begin
                        n_status = STS_BADPOS;
                    end else begin
                        w_cmd.op = OP_DELETE;
                        n_count  = r_count - CW'(1);
                    end
                end
                ACT_READ: begin
                    if (r_pos >= r_count) begin
                        n_status = STS_BADPOS;
                    end else begin
                        n_rdval = w_rdsum;
                    end
                end
                default: n_status = STS_BADPOS;
            endcase
        end else if (r_state == ST_FIND) begin
            n_status = w_any ? STS_OK : STS_NOTFOUND;
            n_found  = w_any ? w_pidx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_rdval  <= n_rdval;
        if (w_exec) begin
            r_match <= w_match;
        end
    end

    // ---- the cell row: each cell sees its left and right neighbour
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WW-1:0] w_l, w_r;
        assign w_l = (g == 0)         ? '0 : w_entry[(g == 0) ? 0 : g - 1];
        assign w_r = (g == DEPTH - 1) ? '0 : w_entry[(g == DEPTH - 1) ? g : g + 1];
        oat_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IW'(g)),
            .i_left  (w_l),
            .i_right (w_r),
            .o_entry (w_entry[g]),
            .o_match (w_match[g]),
            .o_rd    (w_rd[g])
        );
    end

    // only the addressed cell drives a non-zero word
    always_comb begin
        w_rdsum = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rdsum = w_rdsum | w_rd[k];
        end
    end

    oat_prio u_prio (
        .i_vec   (r_match),
        .o_any   (w_any),
        .o_index (w_pidx)
    );

    // ---- result packing
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[IW-1:0]        = r_found;
        m_axis_tdata[IW +: WW]      = r_rdval;
        m_axis_tdata[IW + WW +: CW] = r_count;
        m_axis_tuser                = r_status;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_act == ACT_APPEND && !w_full) |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not grow the fill count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status == STS_FULL) |-> r_count == CW'(DEPTH))
        else $error("full status while not full");

    a_found_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_act == ACT_SEARCH && r_status == STS_OK)
            |-> CW'(r_found) < r_count)
        else $error("search hit beyond fill count");
`endif

endmodule
